[src/hufbp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package hufbp_pkg;

	// opcodes of an input item
	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_ENCODE = 2'd1;
	localparam logic [1:0] OP_FLUSH  = 2'd2;

	// alphabet
	localparam int          SYMBOLS    = 27;
	localparam logic [7:0]  CHAR_A     = 8'd97;
	localparam logic [7:0]  CHAR_Z     = 8'd122;
	localparam logic [7:0]  CHAR_SPACE = 8'd32;
	localparam logic [4:0]  SPACE_SYM  = 5'd26;

	// field widths
	localparam int BYTE_W       = 8;
	localparam int VBITS_W      = 4;
	localparam int SYM_W        = 5;
	localparam int LEN_W        = 5;
	localparam int ENTRY_CODE_W = 26;
	localparam int PEND_W       = 7;
	localparam int LEN_LIMIT    = (1 << LEN_W) - 1;

	localparam int DEF_MAX_CODE_LEN = 26;
	localparam int QUEUE_DEPTH      = 4;

	// control part of a queued command
	typedef struct packed {
		logic             is_flush;
		logic [LEN_W-1:0] len;
	} cmd_ctrl_t;

	// longest length the table can hold
	function automatic int len_max(input int max_len);
		return (max_len < LEN_LIMIT) ? max_len : LEN_LIMIT;
	endfunction

	// stored code width
	function automatic int code_w(input int max_len);
		return (max_len < ENTRY_CODE_W) ? max_len : ENTRY_CODE_W;
	endfunction

	// width of the packer work register: pending bits plus one code
	function automatic int work_w(input int max_len);
		return PEND_W + len_max(max_len);
	endfunction

endpackage
`default_nettype wire

[src/huffman_table_bit_packer_top.sv]
// Table-driven Huffman bit packer.
// Input channel (item_valid / item_stall) carries one item per accept:
//   opcode 0 loads a code word and its length into the 27-entry table,
//   opcode 1 encodes char_byte ('a'..'z' or space, other bytes ignored),
//   opcode 2 flushes pending bits as one zero-padded byte.
// Output channel (result_valid / result_stall) carries the packed bytes,
//   earliest code bit in bit 7; run_last marks the last byte of an input
//   item, flush_byte marks a flush byte with valid_bits below 8.
// The front decodes and looks up the table in the accepting cycle and
//   queues the command; items are taken every cycle while the queue has room.
// The packer emits one byte per cycle while the output is not stalled; the
//   next command is taken once the last full byte has left, so an encode
//   yields up to 4 bytes with 26-bit codes and holds the packer until they
//   have left; the single output byte port sets the pace.
// An item's first byte passes the command queue and then the output register.
// A stalled output holds its byte; the packer then waits once it has a byte
//   to emit, the queue fills and item_stall rises once all queue entries are taken.
// Reset clears the table to zero lengths, the pending bits and the queue.
`timescale 1ns / 1ps
`default_nettype none
module huffman_table_bit_packer_top #(
	parameter int MAX_CODE_LEN = hufbp_pkg::DEF_MAX_CODE_LEN
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               item_valid,
	output logic                                    item_stall,
	input  wire logic [1:0]                         opcode,
	input  wire logic [7:0]                         char_byte,
	input  wire logic [hufbp_pkg::SYM_W-1:0]        entry_symbol,
	input  wire logic [hufbp_pkg::LEN_W-1:0]        entry_length,
	input  wire logic [hufbp_pkg::ENTRY_CODE_W-1:0] entry_code,
	output logic                                    result_valid,
	input  wire logic                               result_stall,
	output logic [hufbp_pkg::BYTE_W-1:0]            out_byte,
	output logic [hufbp_pkg::VBITS_W-1:0]           valid_bits,
	output logic                                    run_last,
	output logic                                    flush_byte
);

	localparam int WORK_W = hufbp_pkg::work_w(MAX_CODE_LEN);
	localparam int CTRL_W = $bits(hufbp_pkg::cmd_ctrl_t);
	localparam int QDW    = CTRL_W + WORK_W;

	logic                 q_push;
	logic                 q_pop;
	logic                 q_full;
	logic                 q_empty;
	hufbp_pkg::cmd_ctrl_t push_ctrl;
	logic [WORK_W-1:0]    push_code;
	hufbp_pkg::cmd_ctrl_t head_ctrl;
	logic [WORK_W-1:0]    head_code;
	logic [QDW-1:0]       head_data;

	// front: table and classification
	hufbp_front #(
		.MAX_CODE_LEN(MAX_CODE_LEN)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.opcode       (opcode),
		.char_byte    (char_byte),
		.entry_symbol (entry_symbol),
		.entry_length (entry_length),
		.entry_code   (entry_code),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_ctrl       (push_ctrl),
		.q_code       (push_code)
	);

	// command queue
	hufbp_fifo #(
		.DW    (QDW),
		.DEPTH (hufbp_pkg::QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({push_ctrl, push_code}),
		.pop       (q_pop),
		.pop_data  (head_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	assign head_ctrl = head_data[QDW-1 -: CTRL_W];
	assign head_code = head_data[WORK_W-1:0];

	// back: bit packer and output register
	hufbp_back #(
		.MAX_CODE_LEN(MAX_CODE_LEN)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_ctrl       (head_ctrl),
		.q_code       (head_code),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_byte     (out_byte),
		.valid_bits   (valid_bits),
		.run_last     (run_last),
		.flush_byte   (flush_byte)
	);

endmodule
`default_nettype wire

[src/hufbp_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module hufbp_front #(
	parameter int MAX_CODE_LEN = hufbp_pkg::DEF_MAX_CODE_LEN
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   item_valid,
	output logic                                        item_stall,
	input  wire logic [1:0]                             opcode,
	input  wire logic [7:0]                             char_byte,
	input  wire logic [hufbp_pkg::SYM_W-1:0]            entry_symbol,
	input  wire logic [hufbp_pkg::LEN_W-1:0]            entry_length,
	input  wire logic [hufbp_pkg::ENTRY_CODE_W-1:0]     entry_code,
	input  wire logic                                   q_full,
	output logic                                        q_push,
	output hufbp_pkg::cmd_ctrl_t                        q_ctrl,
	output logic [hufbp_pkg::work_w(MAX_CODE_LEN)-1:0]  q_code
);

	localparam int CODE_W  = hufbp_pkg::code_w(MAX_CODE_LEN);
	localparam int LEN_MAX = hufbp_pkg::len_max(MAX_CODE_LEN);
	localparam int WORK_W  = hufbp_pkg::work_w(MAX_CODE_LEN);
	localparam int CNT_W   = $clog2(WORK_W + 1);
	localparam int LW      = hufbp_pkg::LEN_W;

	logic [CODE_W-1:0] tbl_code_q [hufbp_pkg::SYMBOLS];
	logic [LW-1:0]     tbl_len_q  [hufbp_pkg::SYMBOLS];

	logic                               accept;
	logic                               load_wr;
	logic [LW-1:0]                      len_sat;
	logic [hufbp_pkg::ENTRY_CODE_W-1:0] code_m;
	logic [hufbp_pkg::SYM_W-1:0]        ch_off;
	logic [hufbp_pkg::SYM_W-1:0]        lk_sym;
	logic                               sym_ok;
	logic [CODE_W-1:0]                  lk_code;
	logic [LW-1:0]                      lk_len;
	logic [CNT_W-1:0]                   align_sh;

	assign item_stall = q_full;
	assign accept     = item_valid && !q_full;

	// load: saturate length and drop code bits above it
	always_comb begin
		if ({1'b0, entry_length} > (LW + 1)'(LEN_MAX)) begin
			len_sat = LW'(LEN_MAX);
		end else begin
			len_sat = entry_length;
		end
		code_m = entry_code & ~({hufbp_pkg::ENTRY_CODE_W{1'b1}} << len_sat);
	end

	assign load_wr = accept && (opcode == hufbp_pkg::OP_LOAD) &&
		(entry_symbol < hufbp_pkg::SYM_W'(hufbp_pkg::SYMBOLS));

	// code table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < hufbp_pkg::SYMBOLS; i++) begin
				tbl_code_q[i] <= '0;
				tbl_len_q[i]  <= '0;
			end
		end else if (load_wr) begin
			tbl_code_q[entry_symbol] <= code_m[CODE_W-1:0];
			tbl_len_q[entry_symbol]  <= len_sat;
		end
	end

	// character to symbol
	always_comb begin
		ch_off = hufbp_pkg::SYM_W'(char_byte - hufbp_pkg::CHAR_A);
		if (char_byte >= hufbp_pkg::CHAR_A && char_byte <= hufbp_pkg::CHAR_Z) begin
			lk_sym = ch_off;
			sym_ok = 1'b1;
		end else if (char_byte == hufbp_pkg::CHAR_SPACE) begin
			lk_sym = hufbp_pkg::SPACE_SYM;
			sym_ok = 1'b1;
		end else begin
			lk_sym = '0;
			sym_ok = 1'b0;
		end
	end

	// lookup and left-align the code in the work width
	always_comb begin
		lk_code  = tbl_code_q[lk_sym];
		lk_len   = tbl_len_q[lk_sym];
		align_sh = CNT_W'(WORK_W) - CNT_W'(lk_len);
		q_code   = {{(WORK_W - CODE_W){1'b0}}, lk_code} << align_sh;
	end

	// classify the item
	always_comb begin
		q_push          = 1'b0;
		q_ctrl.is_flush = 1'b0;
		q_ctrl.len      = lk_len;
		unique case (opcode)
			hufbp_pkg::OP_ENCODE: begin
				q_push = accept && sym_ok && (lk_len != '0);
			end
			hufbp_pkg::OP_FLUSH: begin
				q_push          = accept;
				q_ctrl.is_flush = 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

[src/hufbp_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
module hufbp_fifo #(
	parameter int DW    = 8,
	parameter int DEPTH = hufbp_pkg::QUEUE_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire logic [DW-1:0] push_data,
	input  wire logic          pop,
	output logic    [DW-1:0]   pop_data,
	output logic               full,
	output logic               empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [DW-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full     = (cnt_q == CW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");

endmodule
`default_nettype wire

[src/hufbp_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module hufbp_back #(
	parameter int MAX_CODE_LEN = hufbp_pkg::DEF_MAX_CODE_LEN
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   q_empty,
	input  wire hufbp_pkg::cmd_ctrl_t                   q_ctrl,
	input  wire logic [hufbp_pkg::work_w(MAX_CODE_LEN)-1:0] q_code,
	output logic                                        q_pop,
	output logic                                        result_valid,
	input  wire logic                                   result_stall,
	output logic [hufbp_pkg::BYTE_W-1:0]                out_byte,
	output logic [hufbp_pkg::VBITS_W-1:0]               valid_bits,
	output logic                                        run_last,
	output logic                                        flush_byte
);

	localparam int WORK_W = hufbp_pkg::work_w(MAX_CODE_LEN);
	localparam int CNT_W  = $clog2(WORK_W + 1);
	localparam int BW     = hufbp_pkg::BYTE_W;
	localparam int VW     = hufbp_pkg::VBITS_W;

	// work register holds pending bits left-aligned, zeros below
	logic [WORK_W-1:0] work_q;
	logic [CNT_W-1:0]  wcnt_q;

	logic              res_valid_q;
	logic [BW-1:0]     out_byte_q;
	logic [VW-1:0]     valid_bits_q;
	logic              run_last_q;
	logic              flush_byte_q;

	logic              slot_free;
	logic              have_byte;
	logic [WORK_W-1:0] comb_work;
	logic [CNT_W-1:0]  comb_cnt;
	logic              comb_full;
	logic              need_slot;
	logic              emit;
	logic [BW-1:0]     emit_byte;
	logic [VW-1:0]     emit_vbits;
	logic              emit_last;
	logic              emit_flush;
	logic [WORK_W-1:0] work_d;
	logic [CNT_W-1:0]  wcnt_d;

	assign slot_free = !res_valid_q || !result_stall;
	assign have_byte = (wcnt_q >= CNT_W'(BW));

	// merge the head code behind the pending bits
	always_comb begin
		comb_work = work_q | (q_code >> wcnt_q[2:0]);
		comb_cnt  = wcnt_q + CNT_W'(q_ctrl.len);
		comb_full = (comb_cnt >= CNT_W'(BW));
		if (q_ctrl.is_flush) begin
			need_slot = (wcnt_q != '0);
		end else begin
			need_slot = comb_full;
		end
	end

	// packer step: drain a full byte, else take the next command
	always_comb begin
		q_pop      = 1'b0;
		emit       = 1'b0;
		emit_byte  = work_q[WORK_W-1 -: BW];
		emit_vbits = VW'(BW);
		emit_last  = 1'b0;
		emit_flush = 1'b0;
		work_d     = work_q;
		wcnt_d     = wcnt_q;
		if (have_byte) begin
			if (slot_free) begin
				emit      = 1'b1;
				emit_last = (wcnt_q < CNT_W'(2 * BW));
				work_d    = work_q << BW;
				wcnt_d    = wcnt_q - CNT_W'(BW);
			end
		end else if (!q_empty && (slot_free || !need_slot)) begin
			q_pop = 1'b1;
			if (q_ctrl.is_flush) begin
				if (wcnt_q != '0) begin
					emit       = 1'b1;
					emit_vbits = {1'b0, wcnt_q[2:0]};
					emit_last  = 1'b1;
					emit_flush = 1'b1;
				end
				work_d = '0;
				wcnt_d = '0;
			end else if (comb_full) begin
				emit      = 1'b1;
				emit_byte = comb_work[WORK_W-1 -: BW];
				emit_last = (comb_cnt < CNT_W'(2 * BW));
				work_d    = comb_work << BW;
				wcnt_d    = comb_cnt - CNT_W'(BW);
			end else begin
				work_d = comb_work;
				wcnt_d = comb_cnt;
			end
		end
	end

	// packer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_q <= '0;
			wcnt_q <= '0;
		end else begin
			work_q <= work_d;
			wcnt_q <= wcnt_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q   <= emit_byte;
			valid_bits_q <= emit_vbits;
			run_last_q   <= emit_last;
			flush_byte_q <= emit_flush;
		end
	end

	assign result_valid = res_valid_q;
	assign out_byte     = out_byte_q;
	assign valid_bits   = valid_bits_q;
	assign run_last     = run_last_q;
	assign flush_byte   = flush_byte_q;

	a_pop_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !have_byte)
		else $error("command taken while a full byte is still pending");

	a_flush_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && flush_byte) |-> (run_last && valid_bits != '0 &&
		valid_bits < VW'(BW)))
		else $error("flush result malformed");

	a_encode_full: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !flush_byte) |-> (valid_bits == VW'(BW)))
		else $error("encode result not a full byte");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		wcnt_q <= CNT_W'(WORK_W))
		else $error("pending count beyond work register");

endmodule
`default_nettype wire
